FILE: rtl/dcema_pkg.sv
// Package for the DC removal and smoothing block.
// Holds the fixed-point widths, register indexes and reset values.
// Depends on nothing.
package dcema_pkg;

	localparam int FRAC_BITS = 15;
	localparam int SMOOTH_W  = FRAC_BITS + 11;
	localparam int PROD_W    = SMOOTH_W + 18;
	localparam int TRUNC_W   = SMOOTH_W + 1 - FRAC_BITS;

	localparam int SAMPLE_W  = 8;
	localparam int ALPHA_W   = 16;
	localparam int WINDOW_W  = 21;
	localparam int SUM_W     = 28;
	localparam int CFG_W     = 21;
	localparam int DIV_CNT_W = 5;

	localparam logic [16:0] ALPHA_ONE = 17'd32768;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd32768;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 21'd204800;
	localparam logic [WINDOW_W-1:0] WINDOW_MAX = 21'd1048576;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);
	localparam logic signed [TRUNC_W-1:0] OUT_MAX = TRUNC_W'(127);
	localparam logic signed [TRUNC_W-1:0] OUT_MIN = -TRUNC_W'(128);

	typedef enum logic {
		REG_ALPHA  = 1'b0,
		REG_WINDOW = 1'b1
	} reg_index_t;

endpackage

FILE: rtl/dc_remove_ema_smooth_clamp.sv
// Top level of the DC removal block with exponential moving average smoothing.
// Contains the sequencer, the shared multiplier and the restoring divider.
// Depends on dcema_pkg.
//
// Usage: unsigned 8-bit samples enter on the input channel (in_valid, in_stall,
// sample_in). Each transaction yields one output transaction carrying the
// mean-removed, smoothed and clamped sample and a flag that is set when the
// sample closed a window and the mean was refreshed.
// One shared multiplier forms the two products of the smoothing step in the
// states ST_MUL1 and ST_MUL2; the sum then passes ST_ROUND, ST_CLAMP and ST_RESULT.
// When a sample closes a window, a restoring divider runs one quotient bit per
// cycle until all 28 bits are formed, before the result goes to ST_RESULT.
// The input takes no new sample until the last one has left ST_RESULT, as it
// stalls while a sample is worked on or while its result waits to go out.
// The output register holds a finished result while the receiver stalls, and
// the input is accepted meanwhile; a following result waits until the output
// register is free. A mean refreshed by a sample applies from the next one.
// Reset clears the sum, count, mean and smoothed value, and sets the weight
// to one and the window to 204800 samples. Configuration must be written
// only while the block is idle and no result is pending.
module dc_remove_ema_smooth_clamp
	import dcema_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_W-1:0]        sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       mean_updated
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ROUND,
		ST_CLAMP,
		ST_DIV,
		ST_RESULT
	} state_t;

	state_t                     state_q;
	logic [ALPHA_W-1:0]         alpha_q;
	logic [WINDOW_W-1:0]        window_q;
	logic [SUM_W-1:0]           sum_q;
	logic [WINDOW_W-1:0]        count_q;
	logic [SAMPLE_W-1:0]        mean_q;
	logic signed [SMOOTH_W-1:0] smooth_q;
	logic [16:0]                mul_a_q;
	logic signed [SMOOTH_W-1:0] mul_b_q;
	logic [16:0]                weight_q;
	logic signed [PROD_W-1:0]   acc_q;
	logic [WINDOW_W:0]          rem_q;
	logic [SUM_W-1:0]           quo_q;
	logic [DIV_CNT_W-1:0]       div_cnt_q;
	logic signed [SAMPLE_W-1:0] res_sample_q;
	logic                       res_flag_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_flag_q;

	logic [16:0]                weight;
	logic [WINDOW_W-1:0]        window_eff;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   rounded;
	logic signed [SMOOTH_W:0]   biased;
	logic signed [TRUNC_W-1:0]  whole;
	logic signed [SAMPLE_W-1:0] clamped;
	logic [WINDOW_W:0]          rem_shift;
	logic                       rem_ge;
	logic [WINDOW_W:0]          rem_next;
	logic [SUM_W-1:0]           quo_next;
	logic                       in_accept;
	logic                       out_free;

	always_comb begin
		weight = (alpha_q > ALPHA_ONE[ALPHA_W-1:0]) ? ALPHA_ONE : {1'b0, alpha_q};
		if (window_q == '0) begin
			window_eff = WINDOW_W'(1);
		end else if (window_q > WINDOW_MAX) begin
			window_eff = WINDOW_MAX;
		end else begin
			window_eff = window_q;
		end
	end

	assign diff = $signed({1'b0, sample_in}) - $signed({1'b0, mean_q});
	assign prod = $signed({1'b0, mul_a_q}) * mul_b_q;
	assign rounded = acc_q + $signed(ROUND_HALF);

	assign biased = {smooth_q[SMOOTH_W-1], smooth_q}
		+ (smooth_q[SMOOTH_W-1] ? (SMOOTH_W+1)'((1 << FRAC_BITS) - 1) : '0);
	assign whole = biased[SMOOTH_W:FRAC_BITS];

	always_comb begin
		if (whole > OUT_MAX) begin
			clamped = OUT_MAX[SAMPLE_W-1:0];
		end else if (whole < OUT_MIN) begin
			clamped = OUT_MIN[SAMPLE_W-1:0];
		end else begin
			clamped = whole[SAMPLE_W-1:0];
		end
	end

	assign rem_shift = {rem_q[WINDOW_W-1:0], quo_q[SUM_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, window_eff};
	assign rem_next  = rem_ge ? rem_shift - {1'b0, window_eff} : rem_shift;
	assign quo_next  = {quo_q[SUM_W-2:0], rem_ge};

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_WINDOW: window_q <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sum_q        <= '0;
			count_q      <= '0;
			mean_q       <= '0;
			smooth_q     <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_flag_q   <= 1'b0;
			div_cnt_q    <= '0;
			res_flag_q   <= 1'b0;
			res_sample_q <= '0;
			weight_q     <= '0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			acc_q        <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
		end else begin
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q  <= 1'b1;
				out_sample_q <= res_sample_q;
				out_flag_q   <= res_flag_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						sum_q    <= sum_q + SUM_W'(sample_in);
						count_q  <= count_q + WINDOW_W'(1);
						weight_q <= weight;
						mul_a_q  <= weight;
						mul_b_q  <= SMOOTH_W'(diff);
						state_q  <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					acc_q   <= prod <<< FRAC_BITS;
					mul_a_q <= ALPHA_ONE - weight_q;
					mul_b_q <= smooth_q;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					acc_q   <= acc_q + prod;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					smooth_q <= rounded[15 +: SMOOTH_W];
					state_q  <= ST_CLAMP;
				end
				ST_CLAMP: begin
					res_sample_q <= clamped;
					if (count_q >= window_eff) begin
						rem_q     <= '0;
						quo_q     <= sum_q;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						res_flag_q <= 1'b0;
						state_q    <= ST_RESULT;
					end
				end
				ST_DIV: begin
					rem_q     <= rem_next;
					quo_q     <= quo_next;
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) begin
						mean_q     <= quo_next[SAMPLE_W-1:0];
						sum_q      <= '0;
						count_q    <= '0;
						res_flag_q <= 1'b1;
						state_q    <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = out_sample_q;
	assign mean_updated = out_flag_q;

endmodule

FILE: verif/dc_remove_ema_smooth_clamp_test.sv
// Self-checking testbench for dc_remove_ema_smooth_clamp: a directed table, then random phases.
// Accepted outputs are checked against typed rows' table values, else a cycle-free predictor.
// Depends on dcema_pkg and the dc_remove_ema_smooth_clamp RTL.
module dc_remove_ema_smooth_clamp_test
	import dcema_pkg::*;
();

	localparam longint ONE_Q15     = 32768;
	localparam longint HALF_Q15    = 16384;
	localparam int     STUCK_LIMIT = 2000;
	localparam int     PHASES      = 9;
	localparam int     PHASE_ITEMS = 115;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       flag;
	} dc_result_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		reg_index_t                 idx;
		logic [CFG_W-1:0]           data;
		logic [SAMPLE_W-1:0]        smp;
		bit                         typed;
		logic signed [SAMPLE_W-1:0] want_value;
		logic                       want_flag;
	} script_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	reg_index_t                 cfg_index = REG_ALPHA;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [SAMPLE_W-1:0]        sample_in = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       mean_updated;

	logic [ALPHA_W-1:0]  alpha_reg = ALPHA_RESET;
	logic [WINDOW_W-1:0] window_reg = WINDOW_RESET;
	logic [SUM_W-1:0]    sum_acc = '0;
	logic [WINDOW_W-1:0] count_acc = '0;
	logic [SAMPLE_W-1:0] mean_reg = '0;
	longint              smooth_acc = 0;

	dc_result_t pending_out_q[$];
	int         errors = 0;
	int         stuck = 0;
	bit         calm = 1'b0;

	script_row_t script [28] = '{
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd0,   1'b1, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd255, 1'b1, 8'sd127,  1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd128, 1'b1, 8'sd127,  1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd127, 1'b1, 8'sd127,  1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd1,   1'b1, 8'sd1,    1'b0},
		'{ROW_WRITE,  REG_WINDOW, 21'd0,       8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd200, 1'b1, 8'sd127,  1'b1},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd0,   1'b1, -8'sd128, 1'b1},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd73,  1'b1, 8'sd73,   1'b1},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd72,  1'b1, -8'sd1,   1'b1},
		'{ROW_WRITE,  REG_ALPHA,  21'd0,       8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd255, 1'b1, -8'sd1,   1'b1},
		'{ROW_WRITE,  REG_ALPHA,  21'd65535,   8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd10,  1'b1, -8'sd128, 1'b1},
		'{ROW_WRITE,  REG_ALPHA,  21'h1F4000,  8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd250, 1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd3,   1'b0, 8'sd0,    1'b0},
		'{ROW_WRITE,  REG_WINDOW, 21'h1FFFFF,  8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd5,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd6,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd7,   1'b0, 8'sd0,    1'b0},
		'{ROW_WRITE,  REG_WINDOW, 21'd2,       8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd9,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd100, 1'b0, 8'sd0,    1'b0},
		'{ROW_WRITE,  REG_WINDOW, 21'd1048576, 8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd255, 1'b0, 8'sd0,    1'b0},
		'{ROW_WRITE,  REG_ALPHA,  21'd32768,   8'd0,   1'b0, 8'sd0,    1'b0},
		'{ROW_SAMPLE, REG_ALPHA,  21'd0,       8'd128, 1'b0, 8'sd0,    1'b0}
	};

	dc_remove_ema_smooth_clamp dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.mean_updated (mean_updated)
	);

	always #1 clk = ~clk;

	// One smoothing step: mean removal, Q1.15 weighting with round half up, then the window.
	function automatic dc_result_t dc_ema_step(input logic [SAMPLE_W-1:0] s);
		longint      a;
		longint      d;
		longint      acc;
		longint      v;
		int unsigned win;
		dc_result_t  r;
		a = (alpha_reg > ALPHA_ONE) ? ONE_Q15 : longint'(alpha_reg);
		win = 32'(window_reg);
		if (win == 0)
			win = 1;
		if (win > 32'(WINDOW_MAX))
			win = 32'(WINDOW_MAX);
		sum_acc = sum_acc + SUM_W'(s);
		d = longint'(s) - longint'(mean_reg);
		acc = a * d * (longint'(1) <<< FRAC_BITS) + (ONE_Q15 - a) * smooth_acc;
		smooth_acc = (acc + HALF_Q15) >>> 15;
		v = (smooth_acc >= 0) ? (smooth_acc >>> FRAC_BITS) : -((-smooth_acc) >>> FRAC_BITS);
		if (v > 127)
			v = 127;
		if (v < -128)
			v = -128;
		r.value = v[SAMPLE_W-1:0];
		r.flag = 1'b0;
		count_acc = count_acc + 1'b1;
		if (count_acc >= win) begin
			mean_reg = SAMPLE_W'(32'(sum_acc) / win);
			sum_acc = '0;
			count_acc = '0;
			r.flag = 1'b1;
		end
		return r;
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_ALPHA)
			alpha_reg = val[ALPHA_W-1:0];
		else
			window_reg = val[WINDOW_W-1:0];
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_out_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic feed_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
			input dc_result_t typed_res);
		dc_result_t r;
		if (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			sample_in <= SAMPLE_W'($urandom);
			do @(posedge clk); while ($urandom_range(99) < 13);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		r = dc_ema_step(s);
		pending_out_q.push_back(typed ? typed_res : r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !calm && ($urandom_range(99) < 13);
	end

	// Outputs and handshakes are sampled on the falling edge before the rising edge that takes them.
	always @(negedge clk) begin
		dc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out_q.size() == 0) begin
				$error("sample_out: unexpected transaction, value %0d", sample_out);
				errors++;
			end else begin
				want = pending_out_q.pop_front();
				if (sample_out !== want.value) begin
					$error("sample_out: expected %0d, actual %0d", want.value, sample_out);
					errors++;
				end
				if (mean_updated !== want.flag) begin
					$error("mean_updated: expected %0d, actual %0d", want.flag, mean_updated);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck <= 0;
		else
			stuck <= stuck + 1;
	end

	initial begin
		wait (stuck >= STUCK_LIMIT);
		$display("dc_remove_ema_smooth_clamp_test: errors");
		$finish;
	end

	initial begin
		dc_result_t          r;
		logic [ALPHA_W-1:0]  a;
		logic [CFG_W-1:0]    w;
		logic [SAMPLE_W-1:0] s;
		int                  base;
		int                  t;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				settle();
				write_reg(script[i].idx, script[i].data);
			end else begin
				r.value = script[i].want_value;
				r.flag = script[i].want_flag;
				feed_sample(script[i].smp, script[i].typed, r);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					a = '0;
					w = CFG_W'(1);
				end
				1: begin
					a = ALPHA_RESET;
					w = CFG_W'($urandom_range(2, 16));
				end
				2: begin
					a = '1;
					w = CFG_W'($urandom_range(17, 300));
				end
				3: begin
					a = ALPHA_W'($urandom_range(0, 32768));
					w = WINDOW_RESET;
				end
				4: begin
					a = ALPHA_W'($urandom_range(1, 64));
					w = CFG_W'($urandom_range(1, 8));
				end
				5: begin
					a = ALPHA_W'($urandom_range(32769, 65535));
					w = CFG_W'($urandom_range(1, 64));
				end
				6: begin
					a = ALPHA_W'($urandom_range(0, 32768));
					w = WINDOW_MAX;
				end
				default: begin
					a = ALPHA_W'($urandom_range(8192, 32768));
					w = CFG_W'($urandom_range(1, 64));
				end
			endcase
			calm = (ph == 4);
			write_reg(REG_ALPHA, CFG_W'(a));
			write_reg(REG_WINDOW, w);
			base = $urandom_range(0, 255);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(3))
					0: s = SAMPLE_W'($urandom);
					1: begin
						case ($urandom_range(3))
							0: s = 8'd0;
							1: s = 8'd255;
							2: s = 8'd127;
							default: s = 8'd128;
						endcase
					end
					default: begin
						t = base + int'($urandom_range(0, 40)) - 20;
						if (t < 0)
							t = 0;
						if (t > 255)
							t = 255;
						s = SAMPLE_W'(t);
					end
				endcase
				feed_sample(s, 1'b0, r);
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (pending_out_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("dc_remove_ema_smooth_clamp_test: clean");
		else
			$display("dc_remove_ema_smooth_clamp_test: errors");
		$finish;
	end

endmodule
